/* src/sis_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted integer set package
// Sizes, command and status codes shared by the set and its checker.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

/* src/sis_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sorted_integer_set.sv */
// Each item binary-searches (a RAM read in SRCH, a compare in CMP per probe), then DONE; a
// remove adds a read and a write per shifted entry and a closing step, an add the same plus
// the insert write. One item at a time: a request is taken the cycle after the previous
// result is loaded; a stalled result holds the item until it moves.
// Reset empties the set and drops any pending result; key RAM keeps contents.
// ----------------------------------------------------------------------------
// Sorted integer set
// Ascending key store in RAM with binary search and shift-by-one updates.
// ----------------------------------------------------------------------------
module sorted_integer_set
   import sis_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [KEY_W-1:0]    req_key,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [POS_W-1:0]           rsp_position,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_SHRD = 3'd3;
   localparam logic [2:0] S_SHWR = 3'd4;
   localparam logic [2:0] S_INS  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   logic                    hit_ff, hit_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic                    up_ff, up_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_position_ff, rsp_position_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid_full;
   logic [CNT_W-1:0]        ptr_inc;
   logic [CNT_W-1:0]        ptr_dec;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [KEY_W-1:0]        ram_wdata;
   logic [IDX_W-1:0]        ram_raddr;
   logic [KEY_W-1:0]        ram_rdata;

   sis_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_full = mid_sum[CNT_W:1];
   assign ptr_inc  = ptr_ff + CNT_W'(1);
   assign ptr_dec  = ptr_ff - CNT_W'(1);

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      hit_in          = hit_ff;
      ptr_in          = ptr_ff;
      up_in           = up_ff;
      status_in       = status_ff;
      held_in         = held_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      ram_we          = 1'b0;
      ram_waddr       = lo_ff[IDX_W-1:0];
      ram_wdata       = key_ff;
      ram_raddr       = mid_full[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               key_in   = req_key;
               lo_in    = '0;
               hi_in    = held_ff;
               hit_in   = 1'b0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff != hi_ff) begin
               mid_in   = mid_full[IDX_W-1:0];
               state_in = S_CMP;
            end else begin
               status_in = STATUS_MISS;
               state_in  = S_DONE;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (hit_ff) begin
                        status_in = STATUS_MISS;
                     end else if (held_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        status_in = STATUS_OK;
                        ptr_in    = held_ff;
                        up_in     = 1'b1;
                        state_in  = S_SHRD;
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_ff) begin
                        status_in = STATUS_OK;
                        ptr_in    = lo_ff;
                        up_in     = 1'b0;
                        state_in  = S_SHRD;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (hit_ff) begin
                        status_in = STATUS_OK;
                     end
                  end
                  default: begin
                     status_in = STATUS_MISS;
                  end
               endcase
            end
         end
         S_CMP: begin
            if ($signed(ram_rdata) < key_ff) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in  = CNT_W'(mid_ff);
               hit_in = (ram_rdata == key_ff);
            end
            state_in = S_SRCH;
         end
         S_SHRD: begin
            if (up_ff) begin
               if (ptr_ff == lo_ff) begin
                  state_in = S_INS;
               end else begin
                  ram_raddr = ptr_dec[IDX_W-1:0];
                  state_in  = S_SHWR;
               end
            end else begin
               if (ptr_inc >= held_ff) begin
                  held_in  = held_ff - CNT_W'(1);
                  state_in = S_DONE;
               end else begin
                  ram_raddr = ptr_inc[IDX_W-1:0];
                  state_in  = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[IDX_W-1:0];
            ram_wdata = ram_rdata;
            ptr_in    = up_ff ? ptr_dec : ptr_inc;
            state_in  = S_SHRD;
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff[IDX_W-1:0];
            ram_wdata = key_ff;
            held_in   = held_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_position_in = (status_ff == STATUS_OK) ? POS_W'(lo_ff) : '0;
               rsp_count_in    = COUNT_W'(held_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      hit_ff          <= hit_in;
      ptr_ff          <= ptr_in;
      up_ff           <= up_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

endmodule

/* src/sis_checker.sv */
// ----------------------------------------------------------------------------
// Sorted integer set checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sis_checker
   import sis_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [STATUS_W-1:0]     rsp_status,
   input  logic [POS_W-1:0]        rsp_position,
   input  logic [COUNT_W-1:0]      rsp_count
);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= COUNT_W'(CAPACITY))
      else $error("result count beyond capacity");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_position == '0)
      else $error("position not zero on failed item");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == COUNT_W'(CAPACITY))
      else $error("full status with store not full");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> COUNT_W'(rsp_position) <= rsp_count)
      else $error("position beyond count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_count))
      else $error("stalled result changed");

endmodule

bind sorted_integer_set sis_checker u_sis_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_cmd      (req_cmd),
   .req_key      (req_key),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position),
   .rsp_count    (rsp_count)
);
